>>> src/dsle_pkg.sv
// ----------------------------------------------------------------------------
// dsle_pkg
// Types and constants shared by the link engine front end, core and top level.
// ----------------------------------------------------------------------------
`default_nettype none
package dsle_pkg;

  localparam int unsigned FrameDepth = 256;
  localparam int unsigned FrameAw    = $clog2(FrameDepth);
  localparam int unsigned CntW       = FrameAw + 1;

  localparam logic [1:0] KIND_OCTET  = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [3:0] CMD_NONE      = 4'd0;
  localparam logic [3:0] CMD_NEGPOLL   = 4'd1;
  localparam logic [3:0] CMD_STARTTX   = 4'd2;
  localparam logic [3:0] CMD_NACK      = 4'd3;
  localparam logic [3:0] CMD_ACK       = 4'd4;
  localparam logic [3:0] CMD_ERASE     = 4'd5;
  localparam logic [3:0] CMD_RESTART   = 4'd6;
  localparam logic [3:0] CMD_POWERUP   = 4'd7;
  localparam logic [3:0] CMD_POWERDOWN = 4'd8;
  localparam logic [3:0] CMD_FATAL     = 4'd9;

  localparam logic [2:0] PH_DISABLED = 3'd0;
  localparam logic [2:0] PH_WAITSYNC = 3'd1;
  localparam logic [2:0] PH_WAITPOLL = 3'd2;
  localparam logic [2:0] PH_IDLE     = 3'd3;
  localparam logic [2:0] PH_LENLOW   = 3'd4;
  localparam logic [2:0] PH_RECV     = 3'd5;
  localparam logic [2:0] PH_WAITACK  = 3'd6;
  localparam logic [2:0] PH_TRANSMIT = 3'd7;

  localparam logic [2:0] REG_POLL = 3'd0;
  localparam logic [2:0] REG_RXTO = 3'd1;
  localparam logic [2:0] REG_ACKTO = 3'd2;
  localparam logic [2:0] REG_TXTO = 3'd3;
  localparam logic [2:0] REG_SYNCTO = 3'd4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_octet;
    logic       tx_queue_empty;
    logic       tx_idle;
    logic       signal_detected;
    logic       loop_in_sync;
  } in_item_t;

  typedef struct packed {
    logic [3:0] command;
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       frame_done;
    logic       frame_intact;
    logic [8:0] frame_length;
    logic       enhanced_valid;
    logic       enhanced_mode;
    logic       connected_change;
    logic       connected;
    logic [2:0] link_state;
  } out_item_t;

  // Classified item handed from front end to core
  typedef struct packed {
    logic       is_octet;
    logic       is_tick;
    logic       is_status;
    logic       octet_zero;
    logic       octet_short;
    logic       octet_long;
    logic       octet_ack;
    in_item_t   item;
  } cls_item_t;

  localparam int unsigned ClsW = $bits(cls_item_t);

endpackage
`default_nettype wire

>>> src/dsle_front.sv
// ----------------------------------------------------------------------------
// dsle_front
// Decodes the item kind and pre-classifies the octet for the core.
// ----------------------------------------------------------------------------
`default_nettype none
module dsle_front (
  input  var dsle_pkg::in_item_t  item_i,
  output var dsle_pkg::cls_item_t cls_o
);
  import dsle_pkg::*;

  // Classify kind and octet value ranges
  always_comb begin
    cls_o             = '0;
    cls_o.item        = item_i;
    cls_o.is_octet    = (item_i.kind == KIND_OCTET);
    cls_o.is_tick     = (item_i.kind == KIND_TICK);
    cls_o.is_status   = (item_i.kind == KIND_STATUS);
    cls_o.octet_zero  = (item_i.rx_octet == 8'h00);
    cls_o.octet_short = (item_i.rx_octet >= 8'd4) && (item_i.rx_octet <= 8'd127);
    cls_o.octet_long  = (item_i.rx_octet[7:1] == 7'h40);
    cls_o.octet_ack   = (item_i.rx_octet == 8'hAA);
  end

endmodule
`default_nettype wire

>>> src/dsle_fifo.sv
// ----------------------------------------------------------------------------
// dsle_fifo
// Two-entry queue of fixed-width words with full/empty flags.
// ----------------------------------------------------------------------------
`default_nettype none
module dsle_fifo #(
  parameter int unsigned Width = 8
) (
  input  var logic             clk_i,
  input  var logic             rst_ni,
  input  var logic             push_i,
  input  var logic [Width-1:0] data_i,
  output var logic             full_o,
  input  var logic             pop_i,
  output var logic [Width-1:0] data_o,
  output var logic             empty_o
);
  logic [Width-1:0] mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

>>> src/dsle_core.sv
// ----------------------------------------------------------------------------
// dsle_core
// Link state machine, deframer, checksum, timer; one item per unstalled cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module dsle_core (
  input  var logic                clk_i,
  input  var logic                rst_ni,
  input  var logic                take_i,
  input  var dsle_pkg::cls_item_t cls_i,
  input  var logic [2:0]          cfg_poll_i,
  input  var logic [10:0]         cfg_rxto_i,
  input  var logic [10:0]         cfg_ackto_i,
  input  var logic [10:0]         cfg_txto_i,
  input  var logic [10:0]         cfg_syncto_i,
  output var dsle_pkg::out_item_t res_o
);
  import dsle_pkg::*;

  logic [2:0]      phase_q, phase_d;
  logic [10:0]     tmo_q, tmo_d;
  logic            armed_q, armed_d;
  logic [2:0]      poll_q, poll_d;
  logic [8:0]      exp_q, exp_d;
  logic [8:0]      seen_q, seen_d;
  logic [CntW-1:0] stored_q, stored_d;
  logic [7:0]      sum_q, sum_d;
  logic            ovf_q, ovf_d;
  logic [3:0]      lseq_q, lseq_d;
  logic [7:0]      lsum_q, lsum_d;
  logic            conn_q, conn_d;
  logic [7:0]      first_q, first_d;
  logic [7:0]      store_q [FrameDepth];
  logic            wr_en;
  out_item_t       r;

  logic [7:0]  oct;
  logic [8:0]  exp_sum, seen_inc;
  logic [7:0]  sum_m1;
  logic [10:0] tmo_dec;
  logic [2:0]  seq;

  assign oct      = cls_i.item.rx_octet;
  assign exp_sum  = exp_q + {1'b0, oct};
  assign seen_inc = seen_q + 9'd1;
  assign sum_m1   = sum_q - 8'd1;
  assign seq      = first_q[3:1];

  always_comb begin
    phase_d  = phase_q;
    tmo_d    = tmo_q;
    armed_d  = armed_q;
    poll_d   = poll_q;
    exp_d    = exp_q;
    seen_d   = seen_q;
    stored_d = stored_q;
    sum_d    = sum_q;
    ovf_d    = ovf_q;
    lseq_d   = lseq_q;
    lsum_d   = lsum_q;
    conn_d   = conn_q;
    first_d  = first_q;
    wr_en    = 1'b0;
    tmo_dec  = tmo_q;
    r        = '0;
    if (cls_i.is_octet) begin
      case (phase_q)
        PH_WAITPOLL: begin
          if (!cls_i.octet_zero) begin
            poll_d = '0;
          end else if ({1'b0, poll_q} + 4'd1 >= {1'b0, cfg_poll_i}) begin
            phase_d = PH_IDLE;
            armed_d = 1'b0;
          end else begin
            poll_d = poll_q + 3'd1;
          end
        end
        PH_IDLE: begin
          if (cls_i.octet_zero) begin
            if (cls_i.item.tx_queue_empty) begin
              r.command = CMD_NEGPOLL;
            end else begin
              r.command = CMD_STARTTX;
              phase_d = PH_TRANSMIT;
              armed_d = 1'b1;
              tmo_d   = cfg_txto_i;
            end
          end else if (cls_i.octet_short || cls_i.octet_long) begin
            exp_d    = cls_i.octet_short ? {1'b0, oct} : {oct[0], 8'h00};
            stored_d = '0;
            ovf_d    = 1'b0;
            seen_d   = 9'd1;
            sum_d    = oct;
            phase_d  = cls_i.octet_short ? PH_RECV : PH_LENLOW;
            armed_d  = 1'b1;
            tmo_d    = cfg_rxto_i;
          end else begin
            armed_d = 1'b0;
          end
        end
        PH_LENLOW: begin
          exp_d = exp_sum;
          if (exp_sum >= 9'd5 && exp_sum < 9'd305) begin
            sum_d   = sum_q + oct;
            seen_d  = seen_inc;
            phase_d = PH_RECV;
            armed_d = 1'b1;
            tmo_d   = cfg_rxto_i;
          end else begin
            phase_d = PH_IDLE;
            armed_d = 1'b0;
          end
        end
        PH_RECV: begin
          seen_d = seen_inc;
          if (seen_inc < exp_q) begin
            if (stored_q < CntW'(FrameDepth)) begin
              wr_en    = 1'b1;
              if (stored_q == '0) first_d = oct;
              stored_d = stored_q + 1'b1;
              r.payload_byte  = oct;
              r.payload_valid = 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
            sum_d   = sum_q + oct;
            armed_d = 1'b1;
            tmo_d   = cfg_rxto_i;
          end else begin
            sum_d = sum_m1;
            if (sum_m1 != oct) begin
              r.command = CMD_NACK;
            end else begin
              r.command = CMD_ACK;
              if (!({1'b0, seq} == lseq_q && (seq != 3'd0 || sum_m1 == lsum_q))) begin
                lseq_d = {1'b0, seq};
                lsum_d = sum_m1;
                r.frame_done     = 1'b1;
                r.frame_intact   = !ovf_q;
                r.frame_length   = 9'(stored_q);
                r.enhanced_valid = 1'b1;
                r.enhanced_mode  = first_q[4];
              end
            end
            phase_d = PH_IDLE;
            armed_d = 1'b0;
          end
        end
        PH_WAITACK: begin
          r.command = cls_i.octet_ack ? CMD_ERASE : CMD_RESTART;
          phase_d = PH_IDLE;
          armed_d = 1'b0;
        end
        default: ;
      endcase
    end else if (cls_i.is_tick) begin
      if (armed_q && tmo_q != '0) tmo_dec = tmo_q - 11'd1;
      tmo_d = tmo_dec;
      if (phase_q == PH_TRANSMIT && cls_i.item.tx_idle) begin
        phase_d = PH_WAITACK;
        armed_d = 1'b1;
        tmo_d   = cfg_ackto_i;
      end
      if (armed_d && tmo_d == '0) begin
        armed_d = 1'b0;
        case (phase_d)
          PH_WAITSYNC: begin
            r.command = CMD_POWERDOWN;
            phase_d   = PH_DISABLED;
          end
          PH_IDLE, PH_LENLOW, PH_RECV: phase_d = PH_IDLE;
          PH_WAITACK: begin
            r.command = CMD_RESTART;
            phase_d   = PH_IDLE;
          end
          PH_TRANSMIT: r.command = CMD_FATAL;
          default: ;
        endcase
      end
    end else if (cls_i.is_status) begin
      case (phase_q)
        PH_DISABLED: begin
          if (cls_i.item.signal_detected) begin
            r.command = CMD_POWERUP;
            phase_d = PH_WAITSYNC;
            armed_d = 1'b1;
            tmo_d   = cfg_syncto_i;
          end
        end
        PH_WAITSYNC: begin
          if (!cls_i.item.signal_detected) begin
            r.command = CMD_POWERDOWN;
            phase_d = PH_DISABLED;
            armed_d = 1'b0;
          end else if (cls_i.item.loop_in_sync) begin
            conn_d = 1'b1;
            r.connected_change = 1'b1;
            phase_d = PH_WAITPOLL;
            armed_d = 1'b0;
            poll_d  = '0;
          end
        end
        default: begin
          if (!cls_i.item.loop_in_sync) begin
            conn_d = 1'b0;
            r.connected_change = 1'b1;
            if (cls_i.item.signal_detected) begin
              phase_d = PH_WAITSYNC;
              armed_d = 1'b1;
              tmo_d   = cfg_syncto_i;
            end else begin
              r.command = CMD_POWERDOWN;
              phase_d = PH_DISABLED;
              armed_d = 1'b0;
            end
          end
        end
      endcase
    end
    r.connected  = conn_d;
    r.link_state = phase_d;
  end

  assign res_o = r;

  // Frame buffer write
  always_ff @(posedge clk_i) begin
    if (take_i && wr_en) begin
      store_q[stored_q[FrameAw-1:0]] <= oct;
    end
  end

  // Hold link state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_DISABLED;
      tmo_q    <= '0;
      armed_q  <= 1'b0;
      poll_q   <= '0;
      exp_q    <= '0;
      seen_q   <= '0;
      stored_q <= '0;
      sum_q    <= '0;
      ovf_q    <= 1'b0;
      lseq_q   <= 4'd8;
      lsum_q   <= '0;
      conn_q   <= 1'b0;
      first_q  <= '0;
    end else if (take_i) begin
      phase_q  <= phase_d;
      tmo_q    <= tmo_d;
      armed_q  <= armed_d;
      poll_q   <= poll_d;
      exp_q    <= exp_d;
      seen_q   <= seen_d;
      stored_q <= stored_d;
      sum_q    <= sum_d;
      ovf_q    <= ovf_d;
      lseq_q   <= lseq_d;
      lsum_q   <= lsum_d;
      conn_q   <= conn_d;
      first_q  <= first_d;
    end
  end

endmodule
`default_nettype wire

>>> src/dchannel_slave_link_engine.sv
// ----------------------------------------------------------------------------
// dchannel_slave_link_engine
// Slave-side link engine for a polled digital line signalling link.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+---------------------
//   input    | push / full           | in_item_i
//   result   | empty / pop           | out_item_o
//   config   | cfg_valid / cfg_ready | cfg_index_i, cfg_data_i
//
// One item per cycle sustained unless either side stalls: front queue feeds the
// state machine, which retires one item per cycle into the result queue (two
// entries each). The core sits combinationally between the registered
// queues, so a result can be popped once it is in the result queue.
// Reset clears state; the frame buffer itself is not cleared.
// Either side may stall independently; config is always ready.
// ----------------------------------------------------------------------------
`default_nettype none
module dchannel_slave_link_engine (
  input  var logic                clk_i,
  input  var logic                rst_ni,
  input  var logic                push,
  output var logic                full,
  input  var dsle_pkg::in_item_t  in_item_i,
  output var logic                empty,
  input  var logic                pop,
  output var dsle_pkg::out_item_t out_item_o,
  input  var logic                cfg_valid,
  output var logic                cfg_ready,
  input  var logic [2:0]          cfg_index_i,
  input  var logic [10:0]         cfg_data_i
);
  import dsle_pkg::*;

  cls_item_t cls, cls_q;
  out_item_t res;
  logic      q_empty, res_full, take;
  logic [2:0]  poll_q;
  logic [10:0] rxto_q, ackto_q, txto_q, syncto_q;

  dsle_front u_front (.item_i(in_item_i), .cls_o(cls));

  dsle_fifo #(.Width(ClsW)) u_inq (
    .clk_i, .rst_ni, .push_i(push), .data_i(cls), .full_o(full),
    .pop_i(take), .data_o(cls_q), .empty_o(q_empty)
  );

  assign take = !q_empty && !res_full;

  dsle_core u_core (
    .clk_i, .rst_ni, .take_i(take), .cls_i(cls_q),
    .cfg_poll_i(poll_q), .cfg_rxto_i(rxto_q), .cfg_ackto_i(ackto_q),
    .cfg_txto_i(txto_q), .cfg_syncto_i(syncto_q), .res_o(res)
  );

  dsle_fifo #(.Width($bits(out_item_t))) u_outq (
    .clk_i, .rst_ni, .push_i(take), .data_i(res), .full_o(res_full),
    .pop_i(pop), .data_o(out_item_o), .empty_o(empty)
  );

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_q   <= 3'd5;
      rxto_q   <= 11'd3;
      ackto_q  <= 11'd7;
      txto_q   <= 11'd1000;
      syncto_q <= 11'd200;
    end else if (cfg_valid) begin
      unique case (cfg_index_i)
        REG_POLL:   poll_q   <= cfg_data_i[2:0];
        REG_RXTO:   rxto_q   <= cfg_data_i;
        REG_ACKTO:  ackto_q  <= cfg_data_i;
        REG_TXTO:   txto_q   <= cfg_data_i;
        REG_SYNCTO: syncto_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the slave link engine. A shadow state machine
// predicts one result per accepted item: line bring-up, poll qualification,
// short and long frames (good, corrupted, duplicate, overflowing),
// transmissions with ack, nack and timeouts, and loss of loop sync. The run
// goes through several register settings, the extremes among them, with
// random stalls on both queue sides.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dsle_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned DrainCycles = 12;
  localparam int GenTickCap = 24;

  logic clk_i, rst_ni;
  logic push, full, empty, pop;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index_i;
  logic [10:0] cfg_data_i;
  in_item_t in_item_i;
  out_item_t out_item_o;

  dchannel_slave_link_engine dut (
    .clk_i, .rst_ni, .push, .full, .in_item_i, .empty, .pop, .out_item_o,
    .cfg_valid, .cfg_ready, .cfg_index_i, .cfg_data_i
  );

  // Shadow registers and link state
  logic [2:0]  poll_need;
  logic [10:0] rx_ticks, ack_ticks, tx_ticks, sync_ticks;
  logic [2:0]  phase;
  logic [10:0] tmo_count;
  logic        tmo_armed;
  logic [2:0]  poll_run;
  logic [8:0]  frame_expect, frame_seen, frame_stored;
  logic [7:0]  frame_sum;
  logic        frame_ovf;
  logic [7:0]  frame_buf [FrameDepth];
  logic [3:0]  last_seq;
  logic [7:0]  last_sum;
  logic        link_up;

  in_item_t  pending_q [$];
  out_item_t result_q [$];
  logic [7:0] last_frame [$];
  int errors, n_items, n_results, n_frames, n_phases;
  bit quiet;

  // Parameters of the phase being generated
  int gen_rx, gen_ack, gen_tx, gen_sync, gen_poll;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  task automatic enter_phase(input logic [2:0] ph, input bit arm, input logic [10:0] ticks);
    phase = ph;
    tmo_armed = arm;
    if (arm) tmo_count = ticks;
    if (ph == PH_WAITPOLL) poll_run = '0;
  endtask

  task automatic begin_frame(input logic [7:0] octet, input logic [8:0] expect_len);
    frame_expect = expect_len;
    frame_stored = '0;
    frame_ovf = 1'b0;
    frame_seen = 9'd1;
    frame_sum = octet;
  endtask

  task automatic predict_item(input in_item_t it);
    out_item_t r;
    logic [7:0] o, first;
    logic [2:0] seq;
    r = '0;
    o = it.rx_octet;
    case (it.kind)
      KIND_OCTET: begin
        case (phase)
          PH_WAITPOLL: begin
            if (o != 8'd0) poll_run = '0;
            else if (int'(poll_run) + 1 >= int'(poll_need)) enter_phase(PH_IDLE, 0, '0);
            else poll_run = poll_run + 3'd1;
          end
          PH_IDLE: begin
            if (o == 8'd0) begin
              if (it.tx_queue_empty) r.command = CMD_NEGPOLL;
              else begin
                r.command = CMD_STARTTX;
                enter_phase(PH_TRANSMIT, 1, tx_ticks);
              end
            end else if (o >= 8'd4 && o <= 8'd127) begin
              begin_frame(o, {1'b0, o});
              enter_phase(PH_RECV, 1, rx_ticks);
            end else if (o == 8'h80 || o == 8'h81) begin
              begin_frame(o, {o[0], 8'h00});
              enter_phase(PH_LENLOW, 1, rx_ticks);
            end else enter_phase(PH_IDLE, 0, '0);
          end
          PH_LENLOW: begin
            frame_expect = frame_expect + 9'(o);
            if (frame_expect >= 9'd5 && frame_expect < 9'd305) begin
              frame_sum = frame_sum + o;
              frame_seen = frame_seen + 9'd1;
              enter_phase(PH_RECV, 1, rx_ticks);
            end else enter_phase(PH_IDLE, 0, '0);
          end
          PH_RECV: begin
            frame_seen = frame_seen + 9'd1;
            if (frame_seen < frame_expect) begin
              if (frame_stored < 9'(FrameDepth)) begin
                frame_buf[frame_stored] = o;
                frame_stored = frame_stored + 9'd1;
                r.payload_byte = o;
                r.payload_valid = 1'b1;
              end else frame_ovf = 1'b1;
              frame_sum = frame_sum + o;
              enter_phase(PH_RECV, 1, rx_ticks);
            end else begin
              frame_sum = frame_sum - 8'd1;
              if (frame_sum != o) r.command = CMD_NACK;
              else begin
                first = frame_buf[0];
                seq = first[3:1];
                r.command = CMD_ACK;
                if (!({1'b0, seq} == last_seq && (seq != 3'd0 || frame_sum == last_sum))) begin
                  last_seq = {1'b0, seq};
                  last_sum = frame_sum;
                  r.frame_done = 1'b1;
                  r.frame_intact = ~frame_ovf;
                  r.frame_length = frame_stored;
                  r.enhanced_valid = 1'b1;
                  r.enhanced_mode = first[4];
                  n_frames++;
                end
              end
              enter_phase(PH_IDLE, 0, '0);
            end
          end
          PH_WAITACK: begin
            r.command = (o == 8'hAA) ? CMD_ERASE : CMD_RESTART;
            enter_phase(PH_IDLE, 0, '0);
          end
          default: ;
        endcase
      end
      KIND_TICK: begin
        if (tmo_armed && tmo_count != '0) tmo_count = tmo_count - 11'd1;
        if (phase == PH_TRANSMIT && it.tx_idle) enter_phase(PH_WAITACK, 1, ack_ticks);
        if (tmo_armed && tmo_count == '0) begin
          tmo_armed = 1'b0;
          case (phase)
            PH_WAITSYNC: begin
              r.command = CMD_POWERDOWN;
              enter_phase(PH_DISABLED, 0, '0);
            end
            PH_IDLE, PH_LENLOW, PH_RECV: enter_phase(PH_IDLE, 0, '0);
            PH_WAITACK: begin
              r.command = CMD_RESTART;
              enter_phase(PH_IDLE, 0, '0);
            end
            PH_TRANSMIT: r.command = CMD_FATAL;
            default: ;
          endcase
        end
      end
      KIND_STATUS: begin
        case (phase)
          PH_DISABLED: begin
            if (it.signal_detected) begin
              r.command = CMD_POWERUP;
              enter_phase(PH_WAITSYNC, 1, sync_ticks);
            end
          end
          PH_WAITSYNC: begin
            if (!it.signal_detected) begin
              r.command = CMD_POWERDOWN;
              enter_phase(PH_DISABLED, 0, '0);
            end else if (it.loop_in_sync) begin
              link_up = 1'b1;
              r.connected_change = 1'b1;
              enter_phase(PH_WAITPOLL, 0, '0);
            end
          end
          default: begin
            if (!it.loop_in_sync) begin
              link_up = 1'b0;
              r.connected_change = 1'b1;
              if (it.signal_detected) enter_phase(PH_WAITSYNC, 1, sync_ticks);
              else begin
                r.command = CMD_POWERDOWN;
                enter_phase(PH_DISABLED, 0, '0);
              end
            end
          end
        endcase
      end
      default: ;
    endcase
    r.connected = link_up;
    r.link_state = phase;
    result_q.push_back(r);
  endtask

  // Reset the shadow state and apply register writes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_need <= 3'd5; rx_ticks <= 11'd3; ack_ticks <= 11'd7;
      tx_ticks <= 11'd1000; sync_ticks <= 11'd200;
      phase <= PH_DISABLED; tmo_count <= '0; tmo_armed <= 1'b0; poll_run <= '0;
      frame_expect <= '0; frame_seen <= '0; frame_stored <= '0; frame_sum <= '0;
      frame_ovf <= 1'b0; last_seq <= 4'd8; last_sum <= '0; link_up <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_i)
        REG_POLL:   poll_need <= cfg_data_i[2:0];
        REG_RXTO:   rx_ticks <= cfg_data_i;
        REG_ACKTO:  ack_ticks <= cfg_data_i;
        REG_TXTO:   tx_ticks <= cfg_data_i;
        REG_SYNCTO: sync_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- driver
  int push_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
      in_item_i <= '0;
      push_gap = 0;
    end else begin
      // Predict on each transfer, then hold, idle or advance
      if (push && !full) begin
        predict_item(in_item_i);
        n_items++;
      end
      if (push && full) begin
        push <= 1'b1;
      end else if (push_gap > 0) begin
        push_gap--;
        push <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        push_gap = $urandom_range(0, 4);
        push <= 1'b0;
      end else if (pending_q.size() > 0) begin
        in_item_i <= pending_q.pop_front();
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  int pop_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
      pop_gap = 0;
    end else begin
      if (pop && !empty) begin
        if (result_q.size() == 0) begin
          $error("result with nothing expected: %p", out_item_o);
          errors++;
        end else begin
          out_item_t e;
          e = result_q.pop_front();
          n_results++;
          if (out_item_o.command !== e.command) begin
            $error("command exp %0d got %0d", e.command, out_item_o.command); errors++;
          end
          if (out_item_o.payload_byte !== e.payload_byte) begin
            $error("payload_byte exp %0h got %0h", e.payload_byte, out_item_o.payload_byte);
            errors++;
          end
          if (out_item_o.payload_valid !== e.payload_valid) begin
            $error("payload_valid exp %0d got %0d", e.payload_valid, out_item_o.payload_valid);
            errors++;
          end
          if (out_item_o.frame_done !== e.frame_done) begin
            $error("frame_done exp %0d got %0d", e.frame_done, out_item_o.frame_done); errors++;
          end
          if (out_item_o.frame_intact !== e.frame_intact) begin
            $error("frame_intact exp %0d got %0d", e.frame_intact, out_item_o.frame_intact);
            errors++;
          end
          if (out_item_o.frame_length !== e.frame_length) begin
            $error("frame_length exp %0d got %0d", e.frame_length, out_item_o.frame_length);
            errors++;
          end
          if (out_item_o.enhanced_valid !== e.enhanced_valid) begin
            $error("enhanced_valid exp %0d got %0d", e.enhanced_valid, out_item_o.enhanced_valid);
            errors++;
          end
          if (out_item_o.enhanced_mode !== e.enhanced_mode) begin
            $error("enhanced_mode exp %0d got %0d", e.enhanced_mode, out_item_o.enhanced_mode);
            errors++;
          end
          if (out_item_o.connected_change !== e.connected_change) begin
            $error("connected_change exp %0d got %0d", e.connected_change,
                   out_item_o.connected_change);
            errors++;
          end
          if (out_item_o.connected !== e.connected) begin
            $error("connected exp %0d got %0d", e.connected, out_item_o.connected); errors++;
          end
          if (out_item_o.link_state !== e.link_state) begin
            $error("link_state exp %0d got %0d", e.link_state, out_item_o.link_state); errors++;
          end
        end
      end
      // Stall the result side in bursts
      if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        pop_gap = $urandom_range(0, 4);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic add_item(input logic [1:0] kind, input logic [7:0] octet, input bit qempty,
                          input bit txidle, input bit sig, input bit sync);
    in_item_t it;
    it = in_item_t'($bits(in_item_t)'($urandom));
    it.kind = kind;
    if (kind == KIND_OCTET) begin
      it.rx_octet = octet;
      it.tx_queue_empty = qempty;
    end
    if (kind == KIND_TICK) it.tx_idle = txidle;
    if (kind == KIND_STATUS) begin
      it.signal_detected = sig;
      it.loop_in_sync = sync;
    end
    pending_q.push_back(it);
  endtask

  task automatic add_octet(input logic [7:0] o, input bit qempty);
    add_item(KIND_OCTET, o, qempty, 0, 0, 0);
  endtask

  task automatic add_tick(input bit txidle);
    add_item(KIND_TICK, 0, 0, txidle, 0, 0);
  endtask

  task automatic add_status(input bit sig, input bit sync);
    add_item(KIND_STATUS, 0, 0, 0, sig, sync);
  endtask

  // Send a short or long frame; a corrupted one carries a wrong checksum
  task automatic add_frame(input bit long_form, input int len, input bit corrupt);
    logic [7:0] sum, b;
    int n_payload;
    last_frame.delete();
    if (long_form) begin
      last_frame.push_back({7'h40, len[8]});
      last_frame.push_back(len[7:0]);
      n_payload = len - 3;
    end else begin
      last_frame.push_back(len[7:0]);
      n_payload = len - 2;
    end
    for (int i = 0; i < n_payload; i++) begin
      b = 8'($urandom);
      last_frame.push_back(b);
    end
    sum = '0;
    foreach (last_frame[i]) sum = sum + last_frame[i];
    last_frame.push_back(sum - 8'd1 + 8'(corrupt));
    foreach (last_frame[i]) add_octet(last_frame[i], 1'($urandom_range(0, 1)));
  endtask

  task automatic bring_up();
    if ($urandom_range(0, 1)) add_status(1, 0);
    add_status(1, 1);
    repeat (gen_poll + $urandom_range(0, 1)) add_octet(8'd0, 1);
  endtask

  task automatic transmit_exchange();
    int k;
    add_octet(8'd0, 0);
    k = ($urandom_range(0, 5) == 0) ? gen_tx + 1 : $urandom_range(0, 3);
    repeat (k) add_tick(0);
    add_tick(1);
    case ($urandom_range(0, 3))
      0: add_octet(8'($urandom), 1);
      1: repeat (gen_ack + 1) add_tick(1'($urandom_range(0, 1)));
      default: add_octet(8'hAA, 1);
    endcase
  endtask

  task automatic random_action();
    int len;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      if ($urandom_range(0, 3) == 0) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(258, 304) : $urandom_range(5, 40);
        add_frame(1, len, $urandom_range(0, 7) == 0);
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 127) : $urandom_range(4, 20);
        add_frame(0, len, $urandom_range(0, 7) == 0);
      end
    end else if (pick < 47) begin
      foreach (last_frame[i]) add_octet(last_frame[i], 1);
    end else if (pick < 65) begin
      transmit_exchange();
    end else if (pick < 72) begin
      add_octet(8'd0, 1);
    end else if (pick < 80) begin
      repeat ($urandom_range(1, gen_rx + 2)) add_tick(1'($urandom_range(0, 1)));
    end else if (pick < 85) begin
      add_status(1'($urandom_range(0, 1)), 0);
      if ($urandom_range(0, 3) == 0) repeat (gen_sync + 1) add_tick(0);
      bring_up();
    end else if (pick < 88) begin
      add_status(1, 1'($urandom_range(0, 1)));
    end else begin
      add_item(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom), 1'($urandom),
               1'($urandom), 1'($urandom));
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input int value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= 11'(value);
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Long timeouts are written to the block but tick runs stay short
  task automatic set_regs(input int poll, input int rxto, input int ackto, input int txto,
                          input int syncto);
    gen_poll = poll;
    gen_rx = (rxto > GenTickCap) ? GenTickCap : rxto;
    gen_ack = (ackto > GenTickCap) ? GenTickCap : ackto;
    gen_tx = (txto > GenTickCap) ? GenTickCap : txto;
    gen_sync = (syncto > GenTickCap) ? GenTickCap : syncto;
    write_reg(REG_POLL, poll);
    write_reg(REG_RXTO, rxto);
    write_reg(REG_ACKTO, ackto);
    write_reg(REG_TXTO, txto);
    write_reg(REG_SYNCTO, syncto);
    n_phases++;
  endtask

  task automatic drain();
    do @(posedge clk_i); while (pending_q.size() != 0 || push || result_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    in_item_i = '0;
    cfg_valid = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    quiet = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: bring-up paths, poll qualification and each idle octet class
    set_regs(2, 3, 2, 4, 1);
    add_item(KIND_UNUSED, 8'h00, 0, 0, 1, 1);
    add_octet(8'hFF, 0);
    add_status(1, 0);
    add_tick(0);
    add_status(1, 0);
    add_status(0, 1);
    add_status(1, 0);
    add_status(1, 1);
    add_octet(8'd5, 1);
    add_octet(8'd0, 1);
    add_octet(8'd0, 1);
    add_octet(8'd0, 1);
    add_octet(8'd2, 1);
    add_octet(8'hFF, 1);
    add_octet(8'h81, 1);
    add_octet(8'hFF, 1);
    add_frame(0, 4, 0);
    add_octet(8'd0, 0);
    add_tick(1);
    add_octet(8'hAA, 1);
    drain();

    // Extremes, then random settings
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: set_regs(1, 1, 1, 1, 1);
        1: set_regs(7, 2047, 2047, 2047, 2047);
        default: set_regs($urandom_range(1, 7), $urandom_range(1, 6), $urandom_range(1, 10),
                          $urandom_range(1, 20), $urandom_range(1, 20));
      endcase
      bring_up();
      while (pending_q.size() < 160) random_action();
      if (p == 9) quiet = 1'b1;
      drain();
    end

    $display("covered %0d items and %0d results over %0d register settings",
             n_items, n_results, n_phases);
    $display("accepted %0d new frames", n_frames);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
